FILE: rtl/nearest_palette_color_core_assert.svh
// Assertion macros for the checker file of the palette search block.
`ifndef NEAREST_PALETTE_COLOR_CORE_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_CORE_ASSERT_SVH

// Clocked property with an active-low reset that disables the check.
`define NPC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("nearest palette color check failed");

// Same-cycle implication built on the macro above.
`define NPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  `NPC_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

// Next-cycle implication built on the first macro.
`define NPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  `NPC_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

FILE: rtl/npc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package npc_pkg;

  // Field widths fixed by the item format.
  localparam int ChanWidth      = 8;
  localparam int IdxWidth       = 8;
  localparam int SqWidth        = 2 * ChanWidth;
  // Three squared channel differences need two more bits than one square.
  localparam int DistWidth      = SqWidth + 2;
  localparam int PaletteEntries = 256;

  // Starting best distance, larger than any real distance (3*255*255).
  localparam logic [DistWidth-1:0] DistInit = '1;

  // Request codes.
  typedef enum logic {
    CmdWrite  = 1'b0,
    CmdEncode = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [ChanWidth-1:0] red;
    logic [ChanWidth-1:0] green;
    logic [ChanWidth-1:0] blue;
  } color_t;

  // One request as it travels down the cell chain, with the running best match.
  typedef struct packed {
    cmd_e                 cmd;
    logic [IdxWidth-1:0]  entry_index;
    color_t               color;
    logic [IdxWidth-1:0]  best_index;
    logic [DistWidth-1:0] best_dist;
  } item_t;

  // Square of the absolute difference of two channel values.
  function automatic logic [SqWidth-1:0] sq_diff(input logic [ChanWidth-1:0] a,
                                                 input logic [ChanWidth-1:0] b);
    logic [ChanWidth-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return SqWidth'(d) * SqWidth'(d);
  endfunction

  // Sum of squared channel differences between two colors.
  function automatic logic [DistWidth-1:0] color_dist(input color_t p, input color_t e);
    return DistWidth'(sq_diff(p.red, e.red)) + DistWidth'(sq_diff(p.green, e.green))
         + DistWidth'(sq_diff(p.blue, e.blue));
  endfunction

endpackage

`default_nettype wire

FILE: rtl/npc_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One palette entry of the chain. Stage A computes the distance from the
// passing pixel to this entry; stage B folds it into the running best match.
// A write request for this entry updates it as the request enters stage A.
module npc_cell #(
  parameter int CELL_INDEX = 0
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           adv_i,
  input  wire logic           valid_i,
  input  wire npc_pkg::item_t item_i,
  output logic                valid_o,
  output npc_pkg::item_t      item_o
);

  localparam logic [npc_pkg::IdxWidth-1:0] CellIdx = CELL_INDEX[npc_pkg::IdxWidth-1:0];

  npc_pkg::color_t                  entry_q;
  logic                             a_valid_q;
  npc_pkg::item_t                   a_item_q;
  logic [npc_pkg::DistWidth-1:0]    a_dist_q;
  logic [npc_pkg::DistWidth-1:0]    dist_d;
  logic                             wr_hit;
  logic                             b_valid_q;
  npc_pkg::item_t                   b_item_q;
  npc_pkg::item_t                   b_item_d;

  // Distance of the incoming pixel to the stored entry.
  assign dist_d = npc_pkg::color_dist(item_i.color, entry_q);
  assign wr_hit = valid_i && (item_i.cmd == npc_pkg::CmdWrite) &&
                  (item_i.entry_index == CellIdx);

  // Stored palette entry; reset leaves the gray value of this index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '{red: CellIdx, green: CellIdx, blue: CellIdx};
    end else if (adv_i && wr_hit) begin
      entry_q <= item_i.color;
    end
  end

  // Stage A and stage B occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (adv_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  // Keep the earlier entry on a tie: strict less-than only.
  always_comb begin
    b_item_d = a_item_q;
    if ((a_item_q.cmd == npc_pkg::CmdEncode) && (a_dist_q < a_item_q.best_dist)) begin
      b_item_d.best_index = CellIdx;
      b_item_d.best_dist  = a_dist_q;
    end
  end

  // Payload of both stages.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_item_q <= item_i;
      a_dist_q <= dist_d;
      b_item_q <= b_item_d;
    end
  end

  assign valid_o = b_valid_q;
  assign item_o  = b_item_q;

endmodule

`default_nettype wire

FILE: rtl/nearest_palette_color_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Nearest palette color search.
// Input channel (in_valid_i / in_ready_o) takes one request per cycle when
// in_ready_o is high: cmd_i low writes red/green/blue into entry entry_index_i
// (an index at or above PALETTE_ENTRIES is dropped) and gives no result; cmd_i
// high looks up the pixel and gives one result, the index of the entry with the
// smallest sum of squared channel differences, the lowest index on a tie.
// Output channel (out_valid_o / out_ready_i) carries color_index_o.
// Each palette entry lives in a cell of a chain of two-stage cells. A request
// walks the whole chain and then the output register; throughput is one request
// per cycle when not stalled, writes included, and a write is seen by every
// lookup that follows it.
// Reset empties the chain and sets entry i to the gray value (i, i, i); no clear
// sweep follows, so requests are taken from the first cycle after reset.
// When the receiver stalls with a result waiting, the whole chain holds and
// in_ready_o drops in the same cycle.
module nearest_palette_color_core #(
  parameter int PALETTE_ENTRIES = npc_pkg::PaletteEntries
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           cmd_i,
  input  wire logic [npc_pkg::IdxWidth-1:0]   entry_index_i,
  input  wire logic [npc_pkg::ChanWidth-1:0]  red_i,
  input  wire logic [npc_pkg::ChanWidth-1:0]  green_i,
  input  wire logic [npc_pkg::ChanWidth-1:0]  blue_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [npc_pkg::IdxWidth-1:0]        color_index_o
);

  logic                            adv;
  logic                            out_valid_q;
  logic [npc_pkg::IdxWidth-1:0]    color_index_q;
  logic                            valid_c [PALETTE_ENTRIES+1];
  npc_pkg::item_t                  item_c  [PALETTE_ENTRIES+1];

  // The chain moves whenever the output register is free or being emptied.
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // Request entering the chain with no match yet.
  assign valid_c[0]             = in_valid_i;
  assign item_c[0].cmd          = npc_pkg::cmd_e'(cmd_i);
  assign item_c[0].entry_index  = entry_index_i;
  assign item_c[0].color        = '{red: red_i, green: green_i, blue: blue_i};
  assign item_c[0].best_index   = '0;
  assign item_c[0].best_dist    = npc_pkg::DistInit;

  // One cell per palette entry.
  for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
    npc_cell #(
      .CELL_INDEX(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .valid_i(valid_c[k]),
      .item_i (item_c[k]),
      .valid_o(valid_c[k+1]),
      .item_o (item_c[k+1])
    );
  end

  // Output register: only lookups leave a result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= valid_c[PALETTE_ENTRIES] &&
                     (item_c[PALETTE_ENTRIES].cmd == npc_pkg::CmdEncode);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      color_index_q <= item_c[PALETTE_ENTRIES].best_index;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign color_index_o = color_index_q;

endmodule

`default_nettype wire

FILE: rtl/npc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "nearest_palette_color_core_assert.svh"

// Port-level checks of the palette search block.
module npc_checker #(
  parameter int PALETTE_ENTRIES = npc_pkg::PaletteEntries
) (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_ready_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [npc_pkg::IdxWidth-1:0] color_index_o
);

  localparam logic [npc_pkg::IdxWidth:0] EntryLimit = (npc_pkg::IdxWidth+1)'(PALETTE_ENTRIES);

  // A stalled result stays put with the same index.
  `NPC_ASSERT_NEXT(a_result_held, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(color_index_o))

  // With no result waiting, the chain must be taking requests.
  `NPC_ASSERT_IMP(a_ready_when_empty, clk_i, rst_ni, !out_valid_o, in_ready_o)

  // A stalled result holds back the input side too.
  `NPC_ASSERT_IMP(a_stall_backs_up, clk_i, rst_ni, out_valid_o && !out_ready_i, !in_ready_o)

  // A result always names an existing palette entry.
  `NPC_ASSERT_IMP(a_index_in_range, clk_i, rst_ni, out_valid_o, {1'b0, color_index_o} < EntryLimit)

endmodule

bind nearest_palette_color_core npc_checker #(
  .PALETTE_ENTRIES(PALETTE_ENTRIES)
) u_npc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .color_index_o(color_index_o)
);

`default_nettype wire
